FILE: hw/rtl/scb_pkg.sv
// Shared types, microcode table and arithmetic helpers for the seconds to BCD calendar block.
package scb_pkg;

  localparam int EPOCH_W = 32;
  localparam int DAYS_W  = 16;
  localparam int REM_W   = 6;
  localparam int QSTEP   = 4;
  localparam int CNT_W   = $clog2(EPOCH_W / QSTEP);
  localparam int YOFF_W  = 8;
  localparam int MON_W   = 4;
  localparam int PC_W    = 3;

  localparam logic [REM_W-1:0]  DIV_MINSEC      = REM_W'(60);
  localparam logic [REM_W-1:0]  DIV_HOURS       = REM_W'(24);
  localparam logic [YOFF_W-1:0] CENTURY_YOFF    = YOFF_W'(100);
  localparam logic [YOFF_W-1:0] LAST_YOFF       = YOFF_W'(99);
  localparam logic [8:0]        COMMON_YEAR_LEN = 9'd365;
  localparam logic [MON_W-1:0]  FEB             = MON_W'(1);

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t S_WAIT     = PC_W'(0);
  localparam pc_t S_DIV_SEC  = PC_W'(1);
  localparam pc_t S_DIV_MIN  = PC_W'(2);
  localparam pc_t S_DIV_HOUR = PC_W'(3);
  localparam pc_t S_YEAR     = PC_W'(4);
  localparam pc_t S_MONTH    = PC_W'(5);
  localparam pc_t S_EMIT     = PC_W'(6);

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_DIV,
    OP_YEAR,
    OP_MONTH,
    OP_EMIT
  } op_t;

  typedef enum logic [0:0] {
    DSEL_60,
    DSEL_24
  } dsel_t;

  typedef enum logic [1:0] {
    DST_SEC,
    DST_MIN,
    DST_HOUR
  } dst_t;

  typedef enum logic [2:0] {
    COND_IN_VALID,
    COND_DIV_LAST,
    COND_YEAR_FITS,
    COND_MONTH_FITS,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    dsel_t dsel;
    dst_t  dst;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    op_t   op;
    dsel_t dsel;
    dst_t  dst;
    logic  fire;
  } ctrl_t;

  typedef struct packed {
    logic div_last;
    logic year_fits;
    logic month_fits;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QSTEP-1:0] q;
  } divr_t;

  // Each word holds in place until its condition is met, then jumps.
  function automatic ucode_t ucode(input pc_t pc);
    ucode_t w;
    w = '{op: OP_WAIT, dsel: DSEL_60, dst: DST_SEC, cond: COND_IN_VALID, target: S_DIV_SEC};
    unique case (pc)
      S_WAIT: begin
        w = '{op: OP_WAIT, dsel: DSEL_60, dst: DST_SEC, cond: COND_IN_VALID,
              target: S_DIV_SEC};
      end
      S_DIV_SEC: begin
        w = '{op: OP_DIV, dsel: DSEL_60, dst: DST_SEC, cond: COND_DIV_LAST,
              target: S_DIV_MIN};
      end
      S_DIV_MIN: begin
        w = '{op: OP_DIV, dsel: DSEL_60, dst: DST_MIN, cond: COND_DIV_LAST,
              target: S_DIV_HOUR};
      end
      S_DIV_HOUR: begin
        w = '{op: OP_DIV, dsel: DSEL_24, dst: DST_HOUR, cond: COND_DIV_LAST,
              target: S_YEAR};
      end
      S_YEAR: begin
        w = '{op: OP_YEAR, dsel: DSEL_60, dst: DST_SEC, cond: COND_YEAR_FITS,
              target: S_MONTH};
      end
      S_MONTH: begin
        w = '{op: OP_MONTH, dsel: DSEL_60, dst: DST_SEC, cond: COND_MONTH_FITS,
              target: S_EMIT};
      end
      S_EMIT: begin
        w = '{op: OP_EMIT, dsel: DSEL_60, dst: DST_SEC, cond: COND_OUT_FREE,
              target: S_WAIT};
      end
      default: begin
        w = '{op: OP_WAIT, dsel: DSEL_60, dst: DST_SEC, cond: COND_IN_VALID,
              target: S_WAIT};
      end
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_len(input logic [MON_W-1:0] m);
    logic [4:0] d;
    unique case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 5'd31;
      4'd1:                                      d = 5'd28;
      default:                                   d = 5'd30;
    endcase
    return d;
  endfunction

  // Year offset from 2000; valid for 2000..2199.
  function automatic logic is_leap(input logic [YOFF_W-1:0] yoff);
    return (yoff[1:0] == 2'b00) && (yoff != CENTURY_YOFF);
  endfunction

  // Restoring division, QSTEP quotient bits per call.
  function automatic divr_t div_step(input logic [REM_W-1:0] rem,
                                     input logic [QSTEP-1:0] bits,
                                     input logic [REM_W-1:0] d);
    logic [REM_W:0]   r;
    logic [QSTEP-1:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int i = QSTEP - 1; i >= 0; i--) begin
      r = {r[REM_W-1:0], bits[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return '{rem: r[REM_W-1:0], q: q};
  endfunction

  // Values below 100 only; tens by reciprocal multiply.
  function automatic logic [7:0] bin2bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  tt;
    logic [6:0]  ones;
    p    = 15'(v) * 15'd205;
    tens = p[14:11];
    tt   = 7'(tens) * 7'd10;
    ones = v - tt;
    return {tens, ones[3:0]};
  endfunction

endpackage

FILE: hw/rtl/scb_sequencer.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module scb_sequencer
  import scb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  status_t status,
  output ctrl_t   ctrl
);

  pc_t    pc_r;
  pc_t    pc_nxt;
  ucode_t word;
  logic   met;

  always_comb begin
    word = ucode(pc_r);
    unique case (word.cond)
      COND_IN_VALID:   met = in_valid;
      COND_DIV_LAST:   met = status.div_last;
      COND_YEAR_FITS:  met = status.year_fits;
      COND_MONTH_FITS: met = status.month_fits;
      COND_OUT_FREE:   met = status.out_free;
      default:         met = 1'b0;
    endcase
    pc_nxt    = met ? word.target : pc_r;
    ctrl.op   = word.op;
    ctrl.dsel = word.dsel;
    ctrl.dst  = word.dst;
    ctrl.fire = met;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: hw/rtl/scb_datapath.sv
// Datapath: shared constant divider, year and month walk, BCD output register.
module scb_datapath
  import scb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_t              ctrl,
  input  logic [EPOCH_W-1:0] in_epoch_seconds,
  input  logic               out_stall,
  output status_t            status,
  output logic               out_valid,
  output logic [6:0]         out_seconds_bcd,
  output logic [6:0]         out_minutes_bcd,
  output logic [5:0]         out_hours_bcd,
  output logic [5:0]         out_date_bcd,
  output logic [4:0]         out_month_bcd,
  output logic [7:0]         out_year_bcd,
  output logic               out_year_out_of_range
);

  logic [EPOCH_W-1:0] acc_r, acc_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [REM_W-1:0]   sec_r, sec_nxt;
  logic [REM_W-1:0]   min_r, min_nxt;
  logic [4:0]         hour_r, hour_nxt;
  logic [YOFF_W-1:0]  yoff_r, yoff_nxt;
  logic [7:0]         ybcd_r, ybcd_nxt;
  logic [MON_W-1:0]   mon_r, mon_nxt;
  logic               oval_r, oval_nxt;
  logic [6:0]         osec_r, osec_nxt;
  logic [6:0]         omin_r, omin_nxt;
  logic [5:0]         ohour_r, ohour_nxt;
  logic [5:0]         odate_r, odate_nxt;
  logic [4:0]         omon_r, omon_nxt;
  logic [7:0]         oyear_r, oyear_nxt;
  logic               oor_r, oor_nxt;

  logic [REM_W-1:0]  divisor;
  divr_t             dres;
  logic [DAYS_W-1:0] days;
  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        dim;
  logic [7:0]        tmp;

  always_comb begin
    divisor = (ctrl.dsel == DSEL_24) ? DIV_HOURS : DIV_MINSEC;
    dres    = div_step(rem_r, acc_r[EPOCH_W-1 -: QSTEP], divisor);
    days    = acc_r[DAYS_W-1:0];
    leap    = is_leap(yoff_r);
    ylen    = COMMON_YEAR_LEN + 9'(leap);
    dim     = month_len(mon_r) + 5'((mon_r == FEB) && leap);

    status.div_last   = (cnt_r == '1);
    status.year_fits  = (days < DAYS_W'(ylen));
    status.month_fits = (days < DAYS_W'(dim));
    status.out_free   = !oval_r || !out_stall;
  end

  always_comb begin
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    yoff_nxt  = yoff_r;
    ybcd_nxt  = ybcd_r;
    mon_nxt   = mon_r;
    oval_nxt  = oval_r && out_stall;
    osec_nxt  = osec_r;
    omin_nxt  = omin_r;
    ohour_nxt = ohour_r;
    odate_nxt = odate_r;
    omon_nxt  = omon_r;
    oyear_nxt = oyear_r;
    oor_nxt   = oor_r;
    tmp       = '0;

    unique case (ctrl.op)
      OP_WAIT: begin
        if (ctrl.fire) begin
          acc_nxt  = in_epoch_seconds;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          yoff_nxt = '0;
          ybcd_nxt = '0;
          mon_nxt  = '0;
        end
      end
      OP_DIV: begin
        acc_nxt = {acc_r[EPOCH_W-QSTEP-1:0], dres.q};
        rem_nxt = dres.rem;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (ctrl.fire) begin
          rem_nxt = '0;
          unique case (ctrl.dst)
            DST_SEC:  sec_nxt  = dres.rem;
            DST_MIN:  min_nxt  = dres.rem;
            DST_HOUR: hour_nxt = dres.rem[4:0];
            default:  sec_nxt  = dres.rem;
          endcase
        end
      end
      OP_YEAR: begin
        if (!ctrl.fire) begin
          acc_nxt  = EPOCH_W'(days - DAYS_W'(ylen));
          yoff_nxt = yoff_r + YOFF_W'(1);
          if (ybcd_r[3:0] == 4'd9) begin
            ybcd_nxt[3:0] = 4'd0;
            ybcd_nxt[7:4] = (ybcd_r[7:4] == 4'd9) ? 4'd0 : ybcd_r[7:4] + 4'd1;
          end else begin
            ybcd_nxt[3:0] = ybcd_r[3:0] + 4'd1;
          end
        end
      end
      OP_MONTH: begin
        if (!ctrl.fire) begin
          acc_nxt = EPOCH_W'(days - DAYS_W'(dim));
          mon_nxt = mon_r + MON_W'(1);
        end
      end
      OP_EMIT: begin
        if (ctrl.fire) begin
          oval_nxt  = 1'b1;
          tmp       = bin2bcd(7'(sec_r));
          osec_nxt  = tmp[6:0];
          tmp       = bin2bcd(7'(min_r));
          omin_nxt  = tmp[6:0];
          tmp       = bin2bcd(7'(hour_r));
          ohour_nxt = tmp[5:0];
          tmp       = bin2bcd(7'(days[4:0]) + 7'd1);
          odate_nxt = tmp[5:0];
          tmp       = bin2bcd(7'(mon_r) + 7'd1);
          omon_nxt  = tmp[4:0];
          oyear_nxt = ybcd_r;
          oor_nxt   = (yoff_r > LAST_YOFF);
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    sec_r   <= sec_nxt;
    min_r   <= min_nxt;
    hour_r  <= hour_nxt;
    yoff_r  <= yoff_nxt;
    ybcd_r  <= ybcd_nxt;
    mon_r   <= mon_nxt;
    osec_r  <= osec_nxt;
    omin_r  <= omin_nxt;
    ohour_r <= ohour_nxt;
    odate_r <= odate_nxt;
    omon_r  <= omon_nxt;
    oyear_r <= oyear_nxt;
    oor_r   <= oor_nxt;
  end

  assign out_valid             = oval_r;
  assign out_seconds_bcd       = osec_r;
  assign out_minutes_bcd       = omin_r;
  assign out_hours_bcd         = ohour_r;
  assign out_date_bcd          = odate_r;
  assign out_month_bcd         = omon_r;
  assign out_year_bcd          = oyear_r;
  assign out_year_out_of_range = oor_r;

endmodule

FILE: hw/rtl/seconds_to_bcd_calendar.sv
// Top level of the seconds-since-2000 to packed BCD calendar converter.
// Converts a 32-bit count of seconds since 2000-01-01 00:00:00 into BCD seconds,
// minutes, hours, day of month, month and year (modulo 100), with a flag for
// years past 2099. One word is converted at a time by a small microcoded
// sequencer. Each word is loaded, passed through three constant divisions (4
// quotient bits per cycle), walked over the whole years past 2000 (0 to 136)
// and the whole months into the year (0 to 11), and its result is then loaded
// into the result register, which waits while the previous result stays stalled.
// The next word is accepted as soon as the result register is loaded, even while
// that result still waits to be taken.
module seconds_to_bcd_calendar
  import scb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [EPOCH_W-1:0] in_epoch_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         out_seconds_bcd,
  output logic [6:0]         out_minutes_bcd,
  output logic [5:0]         out_hours_bcd,
  output logic [5:0]         out_date_bcd,
  output logic [4:0]         out_month_bcd,
  output logic [7:0]         out_year_bcd,
  output logic               out_year_out_of_range
);

  ctrl_t   ctrl;
  status_t status;

  assign in_stall = (ctrl.op != OP_WAIT);

  scb_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  scb_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctrl                  (ctrl),
    .in_epoch_seconds      (in_epoch_seconds),
    .out_stall             (out_stall),
    .status                (status),
    .out_valid             (out_valid),
    .out_seconds_bcd       (out_seconds_bcd),
    .out_minutes_bcd       (out_minutes_bcd),
    .out_hours_bcd         (out_hours_bcd),
    .out_date_bcd          (out_date_bcd),
    .out_month_bcd         (out_month_bcd),
    .out_year_bcd          (out_year_bcd),
    .out_year_out_of_range (out_year_out_of_range)
  );

endmodule
